@@ src/ili_pkg.sv @@
// Shared types and codes for the interval list intersection unit.
`timescale 1ns / 1ps

package ili_pkg;

  // Request kinds
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_a;   // store the request range into list A
    logic load_b;   // store the request range into list B
    logic init;     // rewind both pointers, drop the pending result
    logic step;     // compare the current pair and advance one pointer
    logic finish;   // flush the final result, clear lists and overflow
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic merge_done;  // one of the pointers has run off its list
  } status_t;

endpackage

@@ src/ili_ctrl.sv @@
// Controller state machine for the interval list intersection unit.
`timescale 1ns / 1ps

module ili_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     kind,
  input  ili_pkg::status_t status,
  output ili_pkg::cmd_t  cmd,
  output logic           busy
);

  ili_pkg::state_t state;
  ili_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ili_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ili_pkg::ST_IDLE: begin
        if (start) begin
          case (kind)
            ili_pkg::KIND_LOAD_A: cmd.load_a = 1'b1;
            ili_pkg::KIND_LOAD_B: cmd.load_b = 1'b1;
            ili_pkg::KIND_COMPUTE: begin
              cmd.init   = 1'b1;
              state_next = ili_pkg::ST_MERGE;
            end
            default: ; // unknown kind: drop
          endcase
        end
      end
      ili_pkg::ST_MERGE: begin
        busy = 1'b1;
        if (status.merge_done) begin
          cmd.finish = 1'b1;
          state_next = ili_pkg::ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = ili_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ src/ili_dp.sv @@
// Datapath for the interval list intersection unit: lists, pointers, merge, result register.
`timescale 1ns / 1ps

module ili_dp #(
  parameter int LIST_DEPTH = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ili_pkg::cmd_t         cmd,
  input  logic [INDEX_BITS-1:0] span_start,
  input  logic [INDEX_BITS:0]   span_end,
  output ili_pkg::status_t      status,
  output logic                  strobe,
  output logic [INDEX_BITS-1:0] out_start,
  output logic [INDEX_BITS:0]   out_end,
  output logic                  is_empty,
  output logic                  overflowed,
  output logic                  last
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  logic [INDEX_BITS-1:0] a_start [LIST_DEPTH];
  logic [INDEX_BITS:0]   a_end   [LIST_DEPTH];
  logic [INDEX_BITS-1:0] b_start [LIST_DEPTH];
  logic [INDEX_BITS:0]   b_end   [LIST_DEPTH];

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic          overflow_flag;
  logic [CW-1:0] ptr_a;
  logic [CW-1:0] ptr_b;

  logic                  pend_valid;
  logic [INDEX_BITS-1:0] pend_start;
  logic [INDEX_BITS:0]   pend_end;

  logic                  range_ok;
  logic [INDEX_BITS-1:0] cur_as;
  logic [INDEX_BITS:0]   cur_ae;
  logic [INDEX_BITS-1:0] cur_bs;
  logic [INDEX_BITS:0]   cur_be;
  logic [INDEX_BITS-1:0] lo;
  logic [INDEX_BITS:0]   hi;
  logic                  hit;
  logic                  adv_a;

  assign range_ok = {1'b0, span_start} < span_end;

  assign cur_as = a_start[ptr_a[AW-1:0]];
  assign cur_ae = a_end[ptr_a[AW-1:0]];
  assign cur_bs = b_start[ptr_b[AW-1:0]];
  assign cur_be = b_end[ptr_b[AW-1:0]];

  assign lo    = (cur_as > cur_bs) ? cur_as : cur_bs;
  assign hi    = (cur_ae < cur_be) ? cur_ae : cur_be;
  assign hit   = {1'b0, lo} < hi;
  assign adv_a = cur_ae < cur_be;

  assign status.merge_done = (ptr_a >= count_a) || (ptr_b >= count_b);

  // List storage, written at the fill count
  always_ff @(posedge clk) begin
    if (cmd.load_a && range_ok && (count_a < FULL)) begin
      a_start[count_a[AW-1:0]] <= span_start;
      a_end[count_a[AW-1:0]]   <= span_end;
    end
    if (cmd.load_b && range_ok && (count_b < FULL)) begin
      b_start[count_b[AW-1:0]] <= span_start;
      b_end[count_b[AW-1:0]]   <= span_end;
    end
  end

  // Fill counts, overflow, pointers, pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
      ptr_a         <= '0;
      ptr_b         <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (cmd.load_a && range_ok) begin
        if (count_a < FULL) begin
          count_a <= count_a + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.load_b && range_ok) begin
        if (count_b < FULL) begin
          count_b <= count_b + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.init) begin
        ptr_a      <= '0;
        ptr_b      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (adv_a) begin
          ptr_a <= ptr_a + CW'(1);
        end else begin
          ptr_b <= ptr_b + CW'(1);
        end
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_a       <= '0;
        count_b       <= '0;
        overflow_flag <= 1'b0;
        pend_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_start <= lo;
      pend_end   <= hi;
    end
  end

  // Result register: a new hit pushes out the one held before it, and finish flushes the held one or an empty marker
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.step && hit && pend_valid) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit && pend_valid) begin
      out_start  <= pend_start;
      out_end    <= pend_end;
      is_empty   <= 1'b0;
      overflowed <= overflow_flag;
      last       <= 1'b0;
    end else if (cmd.finish) begin
      out_start  <= pend_valid ? pend_start : '0;
      out_end    <= pend_valid ? pend_end : '0;
      is_empty   <= !pend_valid;
      overflowed <= overflow_flag;
      last       <= 1'b1;
    end
  end

endmodule

@@ src/interval_list_intersection_unit.sv @@
// Top level of the interval list intersection unit.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// request   in         start & !busy              kind, span_start, span_end
// result    out        strobe (one cycle, no hold) out_start, out_end, is_empty,
//                                                  overflowed, last
//
// A load request leaves busy low; the next request may follow at once. A
// compute request holds busy through every merge step and the final flush,
// as the single compare-and-advance unit walks the two lists.
// Each result shows on strobe for one cycle; the receiver cannot stall it.
// Reset (rst, synchronous) empties both lists and clears the overflow flag;
// list contents are not cleared, only the fill counts.
module interval_list_intersection_unit #(
  parameter int LIST_DEPTH = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [INDEX_BITS-1:0] span_start,
  input  logic [INDEX_BITS:0]   span_end,
  output logic                  strobe,
  output logic [INDEX_BITS-1:0] out_start,
  output logic [INDEX_BITS:0]   out_end,
  output logic                  is_empty,
  output logic                  overflowed,
  output logic                  last
);

  ili_pkg::cmd_t    cmd;
  ili_pkg::status_t status;

  // Sequence loads and the merge walk
  ili_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the lists, walk them, and register each result
  ili_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .span_start (span_start),
    .span_end   (span_end),
    .status     (status),
    .strobe     (strobe),
    .out_start  (out_start),
    .out_end    (out_end),
    .is_empty   (is_empty),
    .overflowed (overflowed),
    .last       (last)
  );

endmodule

@@ src/ili_chk.sv @@
// Port-level checker for the interval list intersection unit, with its bind.
`timescale 1ns / 1ps

module ili_chk #(
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            kind,
  input logic                  strobe,
  input logic [INDEX_BITS-1:0] out_start,
  input logic [INDEX_BITS:0]   out_end,
  input logic                  is_empty,
  input logic                  last
);

  // A run ends with a quiet cycle on the result side
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result strobe right after the final result");

  // An empty marker is always the only, hence final, result
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && is_empty |-> last)
    else $error("empty result not marked last");

  // Emitted ranges are never empty
  a_range_nonempty: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_empty |-> ({1'b0, out_start} < out_end))
    else $error("emitted range is empty");

  // A load request never raises busy
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == ili_pkg::KIND_LOAD_A || kind == ili_pkg::KIND_LOAD_B)
    |=> !busy)
    else $error("load request raised busy");

  // A compute request occupies the unit
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == ili_pkg::KIND_COMPUTE) |=> busy)
    else $error("compute request did not raise busy");

endmodule

bind interval_list_intersection_unit ili_chk #(
  .INDEX_BITS (INDEX_BITS)
) u_ili_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .strobe    (strobe),
  .out_start (out_start),
  .out_end   (out_end),
  .is_empty  (is_empty),
  .last      (last)
);
